### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

### design/dactf_pkg.sv
// ----------------------------------------------------------------------------
// dactf_pkg
// Shared constants, widths and the CORDIC arctangent table (Q.16 degrees).
// ----------------------------------------------------------------------------
package dactf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(TABLE_LEN);

    localparam int RAW_W   = 16;
    localparam int DT_W    = 20;
    localparam int GAIN_W  = 16;
    localparam int ANG_W   = 25;
    localparam int VEC_W   = 27;
    localparam int Z_W     = 26;
    localparam int OP_A_W  = 27;
    localparam int OP_B_W  = 21;
    localparam int PROD_W  = OP_A_W + OP_B_W;
    localparam int ATAN_W  = 23;

    localparam int DEG180_Q16 = 11796480;
    localparam int GAIN_RESET = 1311;
    localparam int GYRO_SCALE = 500;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 104;

    localparam logic REG_Y_GAIN = 1'b0;
    localparam logic REG_X_GAIN = 1'b1;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

### design/dactf_cordic.sv
// ----------------------------------------------------------------------------
// dactf_cordic
// Vectoring CORDIC atan2(y, x), one micro-rotation per cycle, Q.16 degrees.
// ----------------------------------------------------------------------------
module dactf_cordic
    import dactf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [RAW_W-1:0] y_in,
    input  logic signed [RAW_W-1:0] x_in,
    output logic                    done,
    output logic signed [ANG_W-1:0] angle
);

    localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(DEG180_Q16);
    localparam logic signed [Z_W-1:0] Z_MIN = Z_W'(-DEG180_Q16);

    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    zero_reg, zero_next;
    logic                    run_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       step_reg;

    logic signed [VEC_W-1:0] x_ld, y_ld, xs, ys;
    logic [Z_W-1:0]          atan_ext;
    logic                    last_step;
    logic                    y_pos;

    assign x_ld      = {{(VEC_W-RAW_W-8){x_in[RAW_W-1]}}, x_in, 8'd0};
    assign y_ld      = {{(VEC_W-RAW_W-8){y_in[RAW_W-1]}}, y_in, 8'd0};
    assign xs        = x_reg >>> step_reg;
    assign ys        = y_reg >>> step_reg;
    assign atan_ext  = {{(Z_W-ATAN_W){1'b0}}, atan_q16(step_reg)};
    assign last_step = (step_reg == STEP_W'(NSTEPS - 1));
    assign y_pos     = !y_reg[VEC_W-1] && (y_reg != '0);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (start)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in[RAW_W-1])
            begin
                // left half-plane: turn by 180 degrees first
                x_next = -x_ld;
                y_next = -y_ld;
                z_next = y_in[RAW_W-1] ? Z_MIN : Z_MAX;
            end
            else
            begin
                x_next = x_ld;
                y_next = y_ld;
                z_next = '0;
            end
        end
        else if (run_reg)
        begin
            if (y_pos)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_ext;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (last_step)
                    run_reg <= 1'b0;
                else
                    step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        if (zero_reg)
            angle = '0;
        else if (z_reg > Z_MAX)
            angle = ANG_W'(Z_MAX);
        else if (z_reg < Z_MIN)
            angle = ANG_W'(Z_MIN);
        else
            angle = z_reg[ANG_W-1:0];
    end

    assign done = done_reg;

endmodule

### design/dactf_mul.sv
// ----------------------------------------------------------------------------
// dactf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dactf_mul
    import dactf_pkg::*;
(
    input  logic                     clk,
    input  logic signed [OP_A_W-1:0] op_a,
    input  logic signed [OP_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### design/dual_axis_complementary_tilt_filter.sv
// A request is accepted only in idle; a new one is taken after the result
// has been moved to the output register and the sequencer returns to idle.
// Sequence: the single CORDIC unit runs twice, then four passes per axis through
// the shared multiplier. Output register lets the next request start early.
// Reset: asynchronous, active low; gains return to 1311, angle estimates to 0.
// ----------------------------------------------------------------------------
// dual_axis_complementary_tilt_filter
// Two-axis accelerometer/gyro complementary tilt filter, Q.16 degrees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_axis_complementary_tilt_filter
    import dactf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [GAIN_W-1:0]     cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, time_step
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sensor_angle_y, fused_angle_y, fused_angle_x, gyro_rate_x
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD_Y = 3'd1;
    localparam logic [2:0] ST_WAIT_Y = 3'd2;
    localparam logic [2:0] ST_LOAD_X = 3'd3;
    localparam logic [2:0] ST_WAIT_X = 3'd4;
    localparam logic [2:0] ST_FUSE   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic [1:0] K_RATE = 2'd0;
    localparam logic [1:0] K_ACC  = 2'd1;
    localparam logic [1:0] K_PRED = 2'd2;
    localparam logic [1:0] K_LAST = 2'd3;

    localparam logic signed [ANG_W-1:0] GYRO_K = ANG_W'(GYRO_SCALE);
    localparam logic [OP_B_W-1:0]       ONE_Q16 = OP_B_W'(65536);

    logic [2:0]              state_reg, state_next;
    logic [1:0]              k_reg;
    logic                    axis_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;

    logic [GAIN_W-1:0]       y_gain_reg, x_gain_reg;
    logic signed [ANG_W-1:0] est_y_reg, est_x_reg;

    logic signed [RAW_W-1:0] ax_reg, ay_reg, az_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [ANG_W-1:0] rate_x_reg, rate_y_reg;
    logic signed [ANG_W-1:0] ang_y_reg, ang_x_reg;
    logic signed [OP_A_W-1:0] pred_reg;
    logic signed [PROD_W-1:0] acc_reg;

    logic                    in_acc;
    logic                    out_free;
    logic                    cord_start;
    logic signed [RAW_W-1:0] cord_y;
    logic                    cord_done;
    logic signed [ANG_W-1:0] cord_angle;

    logic signed [OP_A_W-1:0] op_a;
    logic signed [OP_B_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod;

    logic [GAIN_W-1:0]        gain_sel;
    logic signed [ANG_W-1:0]  prev_sel, acc_sel, rate_sel;
    logic signed [PROD_W-1:0] delta_rnd;
    logic signed [OP_A_W-1:0] pred_next;
    logic signed [PROD_W:0]   sum_rnd;
    logic signed [32:0]       sum_q16;
    logic signed [ANG_W-1:0]  est_sat;
    logic signed [ANG_W-1:0]  gx_ext, gy_ext;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ---- shared CORDIC ----
    assign cord_start = (state_reg == ST_LOAD_Y) || (state_reg == ST_LOAD_X);
    assign cord_y     = (state_reg == ST_LOAD_Y) ? ay_reg : ax_reg;

    dactf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .y_in  (cord_y),
        .x_in  (az_reg),
        .done  (cord_done),
        .angle (cord_angle)
    );

    // ---- shared multiplier ----
    assign gain_sel = axis_reg ? x_gain_reg : y_gain_reg;
    assign prev_sel = axis_reg ? est_x_reg  : est_y_reg;
    assign acc_sel  = axis_reg ? ang_x_reg  : ang_y_reg;
    assign rate_sel = axis_reg ? rate_y_reg : rate_x_reg;

    always_comb
    begin
        case (k_reg)
            K_RATE:
            begin
                op_a = OP_A_W'(rate_sel);
                op_b = {{(OP_B_W-DT_W){1'b0}}, dt_reg};
            end
            K_ACC:
            begin
                op_a = OP_A_W'(acc_sel);
                op_b = {{(OP_B_W-GAIN_W){1'b0}}, gain_sel};
            end
            default:
            begin
                op_a = pred_reg;
                op_b = ONE_Q16 - {{(OP_B_W-GAIN_W){1'b0}}, gain_sel};
            end
        endcase
    end

    dactf_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // rate*dt rounded Q.36 -> Q.16, then added to the previous estimate
    assign delta_rnd = prod + PROD_W'(524288);
    assign pred_next = OP_A_W'(prev_sel) + delta_rnd[OP_A_W+19:20];

    // fused Q.32 sum rounded to Q.16 and saturated
    assign sum_rnd   = (PROD_W+1)'(acc_reg) + (PROD_W+1)'(prod) + (PROD_W+1)'(32768);
    assign sum_q16   = sum_rnd[48:16];
    assign est_sat   = (sum_q16[32:24] == {9{sum_q16[32]}}) ? sum_q16[ANG_W-1:0] :
                       (sum_q16[32] ? 25'h1000000 : 25'h0FFFFFF);

    assign gx_ext = ANG_W'(signed'(s_axis_tdata[63:48]));
    assign gy_ext = ANG_W'(signed'(s_axis_tdata[79:64]));

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_LOAD_Y;
            ST_LOAD_Y: state_next = ST_WAIT_Y;
            ST_WAIT_Y: if (cord_done) state_next = ST_LOAD_X;
            ST_LOAD_X: state_next = ST_WAIT_X;
            ST_WAIT_X: if (cord_done) state_next = ST_FUSE;
            ST_FUSE:   if (k_reg == K_LAST && axis_reg) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= K_RATE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            y_gain_reg    <= GAIN_W'(GAIN_RESET);
            x_gain_reg    <= GAIN_W'(GAIN_RESET);
            est_y_reg     <= '0;
            est_x_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == REG_Y_GAIN)
                    y_gain_reg <= cfg_data;
                else if (cfg_index == REG_X_GAIN)
                    x_gain_reg <= cfg_data;
            end

            if (state_reg == ST_FUSE)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == K_LAST)
                begin
                    axis_reg <= !axis_reg;
                    if (axis_reg)
                        est_x_reg <= est_sat;
                    else
                        est_y_reg <= est_sat;
                end
            end
            else
            begin
                k_reg    <= K_RATE;
                axis_reg <= 1'b0;
            end

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg     <= s_axis_tdata[15:0];
            ay_reg     <= s_axis_tdata[31:16];
            az_reg     <= s_axis_tdata[47:32];
            dt_reg     <= s_axis_tdata[99:80];
            rate_x_reg <= gx_ext * GYRO_K;
            rate_y_reg <= gy_ext * GYRO_K;
        end
        if (state_reg == ST_WAIT_Y && cord_done)
            ang_y_reg <= cord_angle;
        if (state_reg == ST_WAIT_X && cord_done)
            ang_x_reg <= cord_angle;
        if (state_reg == ST_FUSE && k_reg == K_ACC)
            pred_reg <= pred_next;
        if (state_reg == ST_FUSE && k_reg == K_PRED)
            acc_reg <= prod;
        if (state_reg == ST_DONE && out_free)
            out_data_reg <= {4'd0, rate_x_reg, est_x_reg, est_y_reg, ang_y_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ASSERT_NEXT(a_accept_starts_y, in_acc, state_reg == ST_LOAD_Y)
    `ASSERT_SAME(a_cordic_done_waited, cord_done, state_reg == ST_WAIT_Y || state_reg == ST_WAIT_X)
    `ASSERT_NEXT(a_fuse_ends_done, state_reg == ST_FUSE && k_reg == K_LAST && axis_reg, state_reg == ST_DONE)

endmodule
